[hw/rtl/hdrs_pkg.sv]
package hdrs_pkg;

    // register indexes of the configuration port
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_ID   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_KIND = 2'd1;
    localparam int CFG_DATA_W = 16;

    // item types
    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;

    // tags of interest
    localparam logic [7:0] TAG_INPUT       = 8'd8;
    localparam logic [7:0] TAG_OUTPUT      = 8'd9;
    localparam logic [7:0] TAG_FEATURE     = 8'd11;
    localparam logic [7:0] TAG_REPORT_SIZE = 8'd7;
    localparam logic [7:0] TAG_REPORT_ID   = 8'd8;
    localparam logic [7:0] TAG_REPORT_CNT  = 8'd9;
    localparam logic [7:0] TAG_SIGNED_LO   = 8'd1;
    localparam logic [7:0] TAG_SIGNED_HI   = 8'd4;

    // report kinds
    localparam logic [1:0] KIND_INPUT   = 2'd0;
    localparam logic [1:0] KIND_OUTPUT  = 2'd1;
    localparam logic [1:0] KIND_FEATURE = 2'd2;

    // header byte that opens a long item
    localparam logic [7:0] LONG_HEADER = 8'hfe;
    localparam logic [7:0] LONG_MAX_LEN = 8'd4;

    localparam logic [31:0] UNDEF_ID = 32'd65535;
    localparam logic [15:0] BYTES_MAX = 16'hffff;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LONG_LEN,
        PH_LONG_TAG,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [7:0] desc_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic               item_valid;
        logic [1:0]         hdr_type;
        logic [7:0]         hdr_tag;
        logic [2:0]         item_length;
        logic signed [31:0] data_value;
        logic               scan_done;
        logic               descriptor_ok;
        logic [15:0]        report_bytes;
    } out_item_t;

    // one parsed byte, from the parser to the size tracker
    typedef struct packed {
        logic        done;
        logic [1:0]  hdr_type;
        logic [7:0]  hdr_tag;
        logic [2:0]  item_length;
        logic [31:0] data_value;
        logic        bad_len;
        logic        open_item;
    } parse_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] bytes;
    } scan_t;

    // data length of a short item from its size code
    function automatic logic [2:0] short_len(input logic [1:0] code);
        logic [2:0] len;
        unique case (code)
            2'd0: len = 3'd0;
            2'd1: len = 3'd1;
            2'd2: len = 3'd2;
            2'd3: len = 3'd4;
        endcase
        return len;
    endfunction

endpackage

[hw/rtl/hid_descriptor_report_size_scanner.sv]
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_data (desc_byte, last_byte)
// out       output     out_valid / out_ready out_data (item and scan fields)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one descriptor byte is taken per cycle while in_ready is high; its result is in the
// output register the cycle after, so bytes may follow back to back.
// the tracker's multiplier updates the size-times-count product in the same
// cycle as the global item, so a main item right after it sees the new value.
// reset returns to the start of a descriptor with no id; cfg_ready is always high.
// in_ready drops only while a result is held and out_ready is low.
module hid_descriptor_report_size_scanner (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  hdrs_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output hdrs_pkg::out_item_t                   out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hdrs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hdrs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [15:0]         wanted_id_reg;
    logic [1:0]          wanted_kind_reg;
    logic                out_valid_reg;
    hdrs_pkg::out_item_t out_data_reg, out_data_next;
    logic                accept;
    logic                stopped;
    hdrs_pkg::parse_t    parse;
    hdrs_pkg::scan_t     scan;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign accept    = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_id_reg   <= 16'hffff;
            wanted_kind_reg <= hdrs_pkg::KIND_INPUT;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == hdrs_pkg::CFG_WANTED_ID)
                wanted_id_reg <= cfg_data;
            else if (cfg_index == hdrs_pkg::CFG_WANTED_KIND)
                wanted_kind_reg <= cfg_data[1:0];
        end
    end

    hdrs_item_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .hold    (stopped),
        .in_item (in_data),
        .parse   (parse)
    );

    hdrs_size_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .last        (in_data.last_byte),
        .parse       (parse),
        .wanted_id   (wanted_id_reg),
        .wanted_kind (wanted_kind_reg),
        .stopped     (stopped),
        .scan        (scan)
    );

    // result assembly
    always_comb
    begin
        out_data_next = '0;
        if (parse.done)
        begin
            out_data_next.item_valid  = 1'b1;
            out_data_next.hdr_type    = parse.hdr_type;
            out_data_next.hdr_tag     = parse.hdr_tag;
            out_data_next.item_length = parse.item_length;
            out_data_next.data_value  = parse.data_value;
        end
        if (in_data.last_byte)
        begin
            out_data_next.scan_done = 1'b1;
            if (scan.ok)
            begin
                out_data_next.descriptor_ok = 1'b1;
                out_data_next.report_bytes  = scan.bytes;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= parse.done | in_data.last_byte;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[hw/rtl/hdrs_item_parser.sv]
module hdrs_item_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 hold,
    input  hdrs_pkg::in_item_t   in_item,
    output hdrs_pkg::parse_t     parse
);

    hdrs_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  type_reg, type_next;
    logic [7:0]  tag_reg, tag_next;
    logic [2:0]  len_reg, len_next;
    logic [2:0]  left_reg, left_next;
    logic [31:0] acc_reg, acc_next;
    logic        done;
    logic        bad;
    logic [7:0]  b;
    logic [2:0]  pos;
    logic [31:0] val;

    assign b = in_item.desc_byte;
    assign pos = len_reg - left_reg;

    // decode one byte against the current phase
    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        done       = 1'b0;
        bad        = 1'b0;
        unique case (phase_reg)
            hdrs_pkg::PH_HEADER:
            begin
                type_next = b[3:2];
                tag_next  = {4'd0, b[7:4]};
                len_next  = hdrs_pkg::short_len(b[1:0]);
                acc_next  = '0;
                if (b == hdrs_pkg::LONG_HEADER)
                begin
                    phase_next = hdrs_pkg::PH_LONG_LEN;
                end
                else if (len_next == 3'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    left_next  = len_next;
                    phase_next = hdrs_pkg::PH_DATA;
                end
            end
            hdrs_pkg::PH_LONG_LEN:
            begin
                if (b > hdrs_pkg::LONG_MAX_LEN)
                begin
                    bad        = 1'b1;
                    phase_next = hdrs_pkg::PH_HEADER;
                end
                else
                begin
                    len_next   = b[2:0];
                    phase_next = hdrs_pkg::PH_LONG_TAG;
                end
            end
            hdrs_pkg::PH_LONG_TAG:
            begin
                tag_next = b;
                if (len_reg == 3'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    left_next  = len_reg;
                    phase_next = hdrs_pkg::PH_DATA;
                end
            end
            hdrs_pkg::PH_DATA:
            begin
                acc_next  = acc_reg | ({24'd0, b} << {pos[1:0], 3'b000});
                left_next = left_reg - 3'd1;
                if (left_next == 3'd0)
                begin
                    done = 1'b1;
                end
            end
        endcase
        if (done)
        begin
            phase_next = hdrs_pkg::PH_HEADER;
        end
    end

    // sign extension of short global data
    always_comb
    begin
        val = acc_next;
        if (type_next == hdrs_pkg::TYPE_GLOBAL && tag_next >= hdrs_pkg::TAG_SIGNED_LO
            && tag_next <= hdrs_pkg::TAG_SIGNED_HI)
        begin
            unique case (len_next)
                3'd1:    val = {{24{acc_next[7]}}, acc_next[7:0]};
                3'd2:    val = {{16{acc_next[15]}}, acc_next[15:0]};
                3'd3:    val = {{8{acc_next[23]}}, acc_next[23:0]};
                default: val = acc_next;
            endcase
        end
    end

    // a stopped scan consumes bytes without decoding
    always_comb
    begin
        parse.done        = done & ~hold;
        parse.hdr_type    = type_next;
        parse.hdr_tag     = tag_next;
        parse.item_length = len_next;
        parse.data_value  = val;
        parse.bad_len     = bad & ~hold;
        parse.open_item   = ~hold && (phase_next != hdrs_pkg::PH_HEADER);
    end

    // phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hdrs_pkg::PH_HEADER;
        end
        else if (accept)
        begin
            if (in_item.last_byte)
            begin
                phase_reg <= hdrs_pkg::PH_HEADER;
            end
            else if (!hold)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    // item registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= '0;
            tag_reg  <= '0;
            len_reg  <= '0;
            left_reg <= '0;
            acc_reg  <= '0;
        end
        else if (accept)
        begin
            if (in_item.last_byte)
            begin
                type_reg <= '0;
                tag_reg  <= '0;
                len_reg  <= '0;
                left_reg <= '0;
                acc_reg  <= '0;
            end
            else if (!hold)
            begin
                type_reg <= type_next;
                tag_reg  <= tag_next;
                len_reg  <= len_next;
                left_reg <= left_next;
                acc_reg  <= acc_next;
            end
        end
    end

endmodule

[hw/rtl/hdrs_size_tracker.sv]
module hdrs_size_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              last,
    input  hdrs_pkg::parse_t  parse,
    input  logic [15:0]       wanted_id,
    input  logic [1:0]        wanted_kind,
    output logic              stopped,
    output hdrs_pkg::scan_t   scan
);

    logic [31:0] id_reg, id_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] count_reg, count_next;
    logic [63:0] product_reg;
    logic [31:0] total_reg, total_next;
    logic        stopped_reg, stopped_next;
    logic        malformed_reg, malformed_next;
    logic [31:0] wanted32;
    logic        add_en;
    logic        kind_match;
    logic [64:0] sum;
    logic        total_nz;
    logic [15:0] bytes_up;

    assign wanted32 = {16'd0, wanted_id};

    // report kind of the finished main item
    always_comb
    begin
        kind_match = (parse.hdr_tag == hdrs_pkg::TAG_INPUT && wanted_kind == hdrs_pkg::KIND_INPUT)
            || (parse.hdr_tag == hdrs_pkg::TAG_OUTPUT && wanted_kind == hdrs_pkg::KIND_OUTPUT)
            || (parse.hdr_tag == hdrs_pkg::TAG_FEATURE
                && wanted_kind == hdrs_pkg::KIND_FEATURE);
    end

    // global tracking and bit accumulation
    always_comb
    begin
        id_next    = id_reg;
        size_next  = size_reg;
        count_next = count_reg;
        add_en     = 1'b0;
        if (parse.done)
        begin
            if (parse.hdr_type == hdrs_pkg::TYPE_GLOBAL)
            begin
                priority if (parse.hdr_tag == hdrs_pkg::TAG_REPORT_ID)
                    id_next = parse.data_value;
                else if (parse.hdr_tag == hdrs_pkg::TAG_REPORT_CNT)
                    count_next = parse.data_value;
                else if (parse.hdr_tag == hdrs_pkg::TAG_REPORT_SIZE)
                    size_next = parse.data_value;
                else
                    id_next = id_reg;
            end
            else if (parse.hdr_type == hdrs_pkg::TYPE_MAIN && id_reg == wanted32)
            begin
                add_en = kind_match;
            end
        end
        sum = {33'd0, total_reg} + {1'b0, product_reg};
        if (add_en)
            total_next = (sum[64:32] != 33'd0) ? 32'hffff_ffff : sum[31:0];
        else
            total_next = total_reg;
        total_nz = (total_reg != 32'd0) || (add_en && product_reg != 64'd0);
        stopped_next = stopped_reg | parse.bad_len
            | (parse.done & total_nz & (id_next != wanted32));
        malformed_next = malformed_reg | parse.bad_len | (last & parse.open_item);
    end

    // byte count, rounded up and saturated
    always_comb
    begin
        bytes_up = total_next[18:3] + {15'd0, (total_next[2:0] != 3'd0)};
        scan.ok = ~malformed_next;
        if (total_next[31:19] != 13'd0
            || (total_next[18:3] == hdrs_pkg::BYTES_MAX && total_next[2:0] != 3'd0))
            scan.bytes = hdrs_pkg::BYTES_MAX;
        else
            scan.bytes = bytes_up;
    end

    assign stopped = stopped_reg;

    // tracker registers; product is registered together with count and size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg        <= hdrs_pkg::UNDEF_ID;
            size_reg      <= '0;
            count_reg     <= '0;
            product_reg   <= '0;
            total_reg     <= '0;
            stopped_reg   <= 1'b0;
            malformed_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                id_reg        <= hdrs_pkg::UNDEF_ID;
                size_reg      <= '0;
                count_reg     <= '0;
                product_reg   <= '0;
                total_reg     <= '0;
                stopped_reg   <= 1'b0;
                malformed_reg <= 1'b0;
            end
            else
            begin
                id_reg        <= id_next;
                size_reg      <= size_next;
                count_reg     <= count_next;
                product_reg   <= count_next * size_next;
                total_reg     <= total_next;
                stopped_reg   <= stopped_next;
                malformed_reg <= malformed_next;
            end
        end
    end

endmodule

[hw/rtl/hdrs_checker.sv]
module hdrs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input hdrs_pkg::out_item_t out_data
);

    // a held result stays put until transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("held result changed");

    // the input side never stalls while the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // every result carries an item or the end of the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.item_valid || out_data.scan_done)
        else $error("empty result");

    // the report size is zero away from the scan end or on a bad descriptor
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !(out_data.scan_done && out_data.descriptor_ok)
        |-> out_data.report_bytes == 16'd0)
        else $error("report size without a good scan end");

    // decoded data length never exceeds four bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.item_valid |-> out_data.item_length <= 3'd4)
        else $error("item length over four");

endmodule

bind hid_descriptor_report_size_scanner hdrs_checker u_hdrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[tb/hdrs_size_checker.sv]
module hdrs_size_checker
    import hdrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_item_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_item_t              out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     due_count
);

    // results predicted but not yet seen on the output
    out_item_t due_q[$];
    int errs = 0;
    int due_n = 0;
    int n_seen = 0;

    // configuration copy
    logic [15:0] want_id;
    logic [1:0]  want_kind;

    // parser and size tracker state
    phase_t      cur_phase;
    logic [7:0]  head;
    logic [7:0]  left;
    logic [7:0]  cur_len;
    logic [7:0]  cur_tag;
    logic [31:0] accum;
    logic [31:0] rep_id;
    logic [31:0] rep_size;
    logic [31:0] rep_count;
    logic [31:0] bits_total;
    logic        halted;
    logic        broken;

    assign fail_count = errs;
    assign due_count  = due_n;

    task automatic report(input string msg);
        if (errs < 100)
            $display("error: %s", msg);
        errs++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d field %s: got %h, expected %h",
                             n_seen, name, got, want));
    endtask

    // back to the start of a descriptor
    task automatic clear_scan();
        cur_phase  = PH_HEADER;
        head       = '0;
        left       = '0;
        cur_len    = '0;
        cur_tag    = '0;
        accum      = '0;
        rep_id     = UNDEF_ID;
        rep_size   = '0;
        rep_count  = '0;
        bits_total = '0;
        halted     = 1'b0;
        broken     = 1'b0;
    endtask

    // item complete: fill the item fields and update the size tracker
    task automatic close_item(inout out_item_t r);
        logic [1:0]  ty;
        logic [31:0] val;
        logic [63:0] sum;
        logic        hit;
        ty  = head[3:2];
        val = accum;
        if (ty == TYPE_GLOBAL && cur_tag >= TAG_SIGNED_LO && cur_tag <= TAG_SIGNED_HI)
        begin
            case (cur_len)
                8'd1: val = {{24{accum[7]}}, accum[7:0]};
                8'd2: val = {{16{accum[15]}}, accum[15:0]};
                8'd3: val = {{8{accum[23]}}, accum[23:0]};
                default: ;
            endcase
        end
        r.item_valid  = 1'b1;
        r.hdr_type    = ty;
        r.hdr_tag     = cur_tag;
        r.item_length = cur_len[2:0];
        r.data_value  = val;

        if (ty == TYPE_GLOBAL)
        begin
            if (cur_tag == TAG_REPORT_ID)
                rep_id = val;
            else if (cur_tag == TAG_REPORT_CNT)
                rep_count = val;
            else if (cur_tag == TAG_REPORT_SIZE)
                rep_size = val;
        end
        else if (ty == TYPE_MAIN && rep_id == {16'd0, want_id})
        begin
            hit = (cur_tag == TAG_INPUT   && want_kind == KIND_INPUT)  ||
                  (cur_tag == TAG_OUTPUT  && want_kind == KIND_OUTPUT) ||
                  (cur_tag == TAG_FEATURE && want_kind == KIND_FEATURE);
            if (hit)
            begin
                sum = {32'd0, bits_total} + {32'd0, rep_count} * {32'd0, rep_size};
                bits_total = (sum[63:32] != 32'd0) ? '1 : sum[31:0];
            end
        end
        cur_phase = PH_HEADER;
        // bits counted and another id in force: nothing more to parse
        if (bits_total != 32'd0 && rep_id != {16'd0, want_id})
            halted = 1'b1;
    endtask

    // one descriptor byte through the parser; made is set when a result is due
    task automatic scan_byte(input in_item_t it, output logic made, output out_item_t r);
        logic [7:0]  b;
        logic        fin;
        logic [1:0]  slot;
        logic [32:0] rounded;
        b   = it.desc_byte;
        fin = 1'b0;
        r   = '0;
        if (!halted)
        begin
            case (cur_phase)
                PH_HEADER:
                begin
                    head     = b;
                    accum    = '0;
                    cur_tag  = {4'd0, b[7:4]};
                    cur_len  = (b[1:0] == 2'd3) ? 8'd4 : {6'd0, b[1:0]};
                    if (b == LONG_HEADER)
                        cur_phase = PH_LONG_LEN;
                    else if (cur_len == 8'd0)
                        fin = 1'b1;
                    else
                    begin
                        left      = cur_len;
                        cur_phase = PH_DATA;
                    end
                end
                PH_LONG_LEN:
                begin
                    if (b > LONG_MAX_LEN)
                    begin
                        broken    = 1'b1;
                        halted    = 1'b1;
                        cur_phase = PH_HEADER;
                    end
                    else
                    begin
                        cur_len   = b;
                        cur_phase = PH_LONG_TAG;
                    end
                end
                PH_LONG_TAG:
                begin
                    cur_tag = b;
                    if (cur_len == 8'd0)
                        fin = 1'b1;
                    else
                    begin
                        left      = cur_len;
                        cur_phase = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    // little-endian data bytes
                    slot  = 2'(cur_len - left);
                    accum = accum | ({24'd0, b} << (8 * slot));
                    left  = left - 8'd1;
                    if (left == 8'd0)
                        fin = 1'b1;
                end
            endcase
            if (fin)
                close_item(r);
        end

        // end of descriptor: report the size and start over
        if (it.last_byte)
        begin
            if (!halted && cur_phase != PH_HEADER)
                broken = 1'b1;
            r.scan_done = 1'b1;
            if (!broken)
            begin
                r.descriptor_ok = 1'b1;
                rounded = ({1'b0, bits_total} + 33'd7) >> 3;
                r.report_bytes = (rounded > 33'd65535) ? BYTES_MAX : rounded[15:0];
            end
            clear_scan();
        end
        made = fin || it.last_byte;
    endtask

    // watch all three channels at the rising edge
    always @(posedge clk)
    begin : monitor
        out_item_t got;
        out_item_t want;
        out_item_t pred;
        logic      made;
        if (!rst_n)
        begin
            want_id   = UNDEF_ID[15:0];
            want_kind = KIND_INPUT;
            clear_scan();
            due_q.delete();
        end
        else
        begin
            // output transfer against the oldest prediction
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (due_q.size() == 0)
                    report($sformatf("result %0d with nothing expected: %h", n_seen, got));
                else
                begin
                    want = due_q.pop_front();
                    check_field("item_valid",    got.item_valid,    want.item_valid);
                    check_field("hdr_type",      got.hdr_type,      want.hdr_type);
                    check_field("hdr_tag",       got.hdr_tag,       want.hdr_tag);
                    check_field("item_length",   got.item_length,   want.item_length);
                    check_field("data_value",    got.data_value,    want.data_value);
                    check_field("scan_done",     got.scan_done,     want.scan_done);
                    check_field("descriptor_ok", got.descriptor_ok, want.descriptor_ok);
                    check_field("report_bytes",  got.report_bytes,  want.report_bytes);
                end
                n_seen++;
            end

            // input transfer
            if (in_valid && in_ready)
            begin
                scan_byte(in_data, made, pred);
                if (made)
                    due_q.push_back(pred);
            end

            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WANTED_ID:   want_id = cfg_data;
                    CFG_WANTED_KIND: want_kind = cfg_data[1:0];
                    default: ;
                endcase
            end
        end
        due_n <= due_q.size();
    end

endmodule

[tb/tb_hid_descriptor_report_size_scanner.sv]
module tb_hid_descriptor_report_size_scanner;

    import hdrs_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_BYTES = 305;
    localparam int N_PHASES    = 6;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     due_count;

    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic hold_req = 1'b0;
    logic [7:0] desc_q[$];
    int sent = 0;

    hid_descriptor_report_size_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hdrs_size_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin : rx_drive
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                out_ready <= !(rx_idle_on && ($urandom_range(99) < 24));
        end
    end

    // stop the run when no transfer happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // one byte transfer, with random gaps before it
    task automatic send_byte(input logic [7:0] b, input logic l);
        in_item_t it;
        it.desc_byte = b;
        it.last_byte = l;
        @(negedge clk);
        while (tx_idle_on && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // send the queued descriptor, last flag on its final byte
    task automatic send_desc();
        foreach (desc_q[i])
            send_byte(desc_q[i], i == desc_q.size() - 1);
        desc_q.delete();
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain all predicted results, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // short item: header then its data bytes, little-endian
    task automatic add_item(input logic [7:0] hdr, input logic [31:0] val);
        int n;
        n = (hdr[1:0] == 2'd3) ? 4 : int'(hdr[1:0]);
        desc_q.push_back(hdr);
        for (int i = 0; i < n; i++)
            desc_q.push_back(val[8*i +: 8]);
    endtask

    task automatic add_long(input int len, input logic [7:0] tag);
        desc_q.push_back(LONG_HEADER);
        desc_q.push_back(8'(len));
        desc_q.push_back(tag);
        repeat (len) desc_q.push_back(8'($urandom));
    endtask

    // mostly well-formed descriptors around the wanted id, some noise and cuts
    task automatic build_descriptor(input logic [15:0] want);
        int n_items;
        int sel;
        int cut;
        logic [7:0] hdr;
        logic [3:0] tg;
        desc_q.delete();
        if ($urandom_range(99) < 5)
        begin
            repeat ($urandom_range(1, 10)) desc_q.push_back(8'($urandom));
            return;
        end
        n_items = $urandom_range(1, 12);
        repeat (n_items)
        begin
            sel = $urandom_range(99);
            if (sel < 12)
            begin
                // report id
                case ($urandom_range(3))
                    0: add_item(8'h86, {16'd0, want});
                    1: add_item(8'h85, $urandom_range(1, 3));
                    2: add_item(8'h86, {16'd0, want ^ 16'd1});
                    default: add_item(8'h84 | 8'($urandom_range(3)), $urandom);
                endcase
            end
            else if (sel < 24)
            begin
                // report size
                if ($urandom_range(9) == 0)
                    add_item(8'h74 | 8'($urandom_range(3)), $urandom);
                else
                    add_item(8'h75, $urandom_range(1, 16));
            end
            else if (sel < 36)
            begin
                // report count
                if ($urandom_range(9) == 0)
                    add_item(8'h94 | 8'($urandom_range(3)), $urandom);
                else
                    add_item(8'h95, $urandom_range(0, 8));
            end
            else if (sel < 66)
            begin
                // input, output or feature
                case ($urandom_range(2))
                    0: tg = TAG_INPUT[3:0];
                    1: tg = TAG_OUTPUT[3:0];
                    default: tg = TAG_FEATURE[3:0];
                endcase
                hdr = {tg, TYPE_MAIN, 2'($urandom_range(3))};
                add_item(hdr, $urandom);
            end
            else if (sel < 74)
            begin
                // collection and end collection
                if ($urandom_range(1) == 0)
                    add_item(8'ha1, $urandom);
                else
                    add_item(8'hc0, 32'd0);
            end
            else if (sel < 88)
            begin
                // other global or local items, signed ones among them
                hdr = {4'($urandom), ($urandom_range(1) == 0) ? 2'b01 : 2'b10, 2'($urandom)};
                add_item(hdr, $urandom);
            end
            else if (sel < 94)
                add_long($urandom_range(0, 4), 8'($urandom));
            else if (sel < 96)
            begin
                // long item with a bad length, then leftovers
                desc_q.push_back(LONG_HEADER);
                desc_q.push_back(8'($urandom_range(5, 255)));
                repeat ($urandom_range(0, 3)) desc_q.push_back(8'($urandom));
            end
            else
            begin
                hdr = 8'($urandom);
                if (hdr == LONG_HEADER)
                    hdr = 8'hff;
                add_item(hdr, $urandom);
            end
        end
        // cut the tail to end inside an item
        if ($urandom_range(99) < 8 && desc_q.size() > 1)
        begin
            cut = $urandom_range(1, 3);
            if (cut >= desc_q.size())
                cut = desc_q.size() - 1;
            repeat (cut) void'(desc_q.pop_back());
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        logic [15:0] ids [N_PHASES];
        logic [1:0]  kinds [N_PHASES];
        int stop_at;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;

        ids[0] = UNDEF_ID[15:0];  kinds[0] = KIND_INPUT;
        ids[1] = 16'd0;           kinds[1] = KIND_OUTPUT;
        ids[2] = 16'd1;           kinds[2] = KIND_FEATURE;
        ids[3] = 16'($urandom);   kinds[3] = 2'd3;
        ids[4] = 16'd2;           kinds[4] = KIND_INPUT;
        ids[5] = 16'($urandom);   kinds[5] = 2'($urandom_range(2));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, registers at their reset values
        // size and count feed an input item, then a new id ends the scan early
        desc_q = '{8'h75, 8'h08, 8'h95, 8'h02, 8'h81, 8'h02, 8'h85, 8'h01, 8'hc0};
        send_desc();
        // size times count past the byte limit, then past 32 bits of bits
        desc_q = '{8'h76, 8'hff, 8'hff, 8'h96, 8'hff, 8'hff, 8'h80, 8'h80};
        send_desc();
        // sign extension of one and two byte globals, then a long item
        desc_q = '{8'h15, 8'h80, 8'h26, 8'h00, 8'h80, LONG_HEADER, 8'h01, 8'h55, 8'haa};
        send_desc();
        // long item with a data length over four
        desc_q = '{LONG_HEADER, 8'h05, 8'h00};
        send_desc();
        // descriptor cut inside an item
        desc_q = '{8'h75};
        send_desc();
        settle();

        // random phases, one register setting each
        for (int p = 0; p < N_PHASES; p++)
        begin
            tx_idle_on = (p != 1);
            rx_idle_on = (p != 1);
            if (p == 0 || p == 4)
                hold_req = 1'b1;
            write_reg(CFG_WANTED_ID, ids[p]);
            write_reg(CFG_WANTED_KIND, (16'($urandom) & 16'hfffc) | {14'd0, kinds[p]});
            if (p == 3)
            begin
                write_reg(CFG_SPARE_A, 16'($urandom));
                write_reg(CFG_SPARE_B, 16'($urandom));
            end
            stop_at = sent + PHASE_BYTES;
            while (sent < stop_at)
            begin
                build_descriptor(ids[p]);
                send_desc();
            end
            settle();
        end

        if (fail_count == 0 && due_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/hdrs_pkg.sv
hw/rtl/hdrs_item_parser.sv
hw/rtl/hdrs_size_tracker.sv
hw/rtl/hid_descriptor_report_size_scanner.sv
hw/rtl/hdrs_checker.sv
tb/hdrs_size_checker.sv
tb/tb_hid_descriptor_report_size_scanner.sv
